### design/plvl_pkg.sv
package plvl_pkg;

	localparam int BOOK_LEVELS = 64;
	localparam int SNAPSHOT_LEVELS = 64;
	localparam int BK_CW = $clog2(BOOK_LEVELS + 1);
	localparam int ST_CW = $clog2(SNAPSHOT_LEVELS + 1);
	localparam int PW = 31;

	localparam logic [1:0] ACT_UPDATE = 2'd0;
	localparam logic [1:0] ACT_SNAPSHOT = 2'd1;
	localparam logic [1:0] ACT_TRADE = 2'd2;
	localparam logic [1:0] ACT_QUERY = 2'd3;

	localparam logic [2:0] STS_OK = 3'd0;
	localparam logic [2:0] STS_BAD_PRICE = 3'd1;
	localparam logic [2:0] STS_NEG_QTY = 3'd2;
	localparam logic [2:0] STS_CROSSED = 3'd3;
	localparam logic [2:0] STS_IGNORED = 3'd4;

	localparam logic [1:0] POL_REJECT = 2'd0;
	localparam logic [1:0] POL_DROP = 2'd1;

	localparam logic CFG_MAX_DEPTH = 1'b0;
	localparam logic CFG_POLICY = 1'b1;

	localparam logic SIDE_BID = 1'b0;

	typedef enum logic [2:0] {
		CMD_HOLD,
		CMD_REMOVE,
		CMD_QTY,
		CMD_INSERT,
		CMD_POP,
		CMD_LOAD
	} cell_cmd_t;

	typedef struct packed {
		cell_cmd_t cmd;
		logic side;
	} cell_ctl_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_COMMIT,
		S_DROP,
		S_TRIM,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [1:0] action;
		logic side;
		logic signed [31:0] price;
		logic signed [31:0] quantity;
		logic [5:0] query_index;
		logic last;
	} in_item_t;

	typedef struct packed {
		logic [2:0] status;
		logic [30:0] best_bid_price;
		logic [30:0] best_bid_qty;
		logic [30:0] best_ask_price;
		logic [30:0] best_ask_qty;
		logic [6:0] bid_count;
		logic [6:0] ask_count;
		logic crossed;
		logic [31:0] snapshot_count;
		logic level_found;
		logic [30:0] level_price;
		logic [30:0] level_qty;
	} out_item_t;

endpackage

### design/plvl_cell.sv
module plvl_cell (
	input logic clk,
	input plvl_pkg::cell_ctl_t ctl,
	input logic valid,
	input logic [plvl_pkg::PW-1:0] key_p,
	input logic [plvl_pkg::PW-1:0] key_q,
	input logic prev_better,
	input logic [plvl_pkg::PW-1:0] left_p,
	input logic [plvl_pkg::PW-1:0] left_q,
	input logic [plvl_pkg::PW-1:0] right_p,
	input logic [plvl_pkg::PW-1:0] right_q,
	input logic [plvl_pkg::PW-1:0] ext_p,
	input logic [plvl_pkg::PW-1:0] ext_q,
	output logic [plvl_pkg::PW-1:0] lvl_p,
	output logic [plvl_pkg::PW-1:0] lvl_q,
	output logic better,
	output logic match
);

	logic [plvl_pkg::PW-1:0] p_q;
	logic [plvl_pkg::PW-1:0] q_q;

	// better: this level sorts ahead of the key on this side
	always_comb begin
		better = valid && (ctl.side ? (p_q < key_p) : (p_q > key_p));
		match = valid && (p_q == key_p);
	end

	assign lvl_p = p_q;
	assign lvl_q = q_q;

	always_ff @(posedge clk) begin
		unique case (ctl.cmd)
			plvl_pkg::CMD_REMOVE: begin
				if (!better) begin
					p_q <= right_p;
					q_q <= right_q;
				end
			end
			plvl_pkg::CMD_QTY: begin
				if (match) begin
					q_q <= key_q;
				end
			end
			plvl_pkg::CMD_INSERT: begin
				if (!better) begin
					if (prev_better) begin
						p_q <= key_p;
						q_q <= key_q;
					end else begin
						p_q <= left_p;
						q_q <= left_q;
					end
				end
			end
			plvl_pkg::CMD_POP: begin
				p_q <= right_p;
				q_q <= right_q;
			end
			plvl_pkg::CMD_LOAD: begin
				p_q <= ext_p;
				q_q <= ext_q;
			end
			default: begin
			end
		endcase
	end

endmodule

### design/price_level_order_book_top.sv
// Price-level order book: two sorted shift chains of cells per side, one for the live book
// and one for snapshot staging. An item is taken, worked on, and its result is placed in
// the output register; the next item is taken once that result has been loaded. After the
// accept, every item passes the execute state. A trade, query, snapshot level that is not
// last, or update that fails its checks or is rejected as crossed then goes to done; a good
// depth update first goes through the drop state (drop policy only) and the trim state; a
// last snapshot level goes to the commit state, and on a good commit also through drop and
// trim. A stalled result register holds the item in the done state until the result loads.
// Every chain operation (insert, delete, quantity change, pop of the best level, snapshot
// copy) is done by all cells of a chain in parallel; the drop loop of the crossed policy is
// what stretches an item.
module price_level_order_book_top (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input plvl_pkg::in_item_t in_data,
	output logic out_valid,
	input logic out_ready,
	output plvl_pkg::out_item_t out_data,
	input logic cfg_we,
	input logic cfg_index,
	input logic [6:0] cfg_data
);

	localparam int BL = plvl_pkg::BOOK_LEVELS;
	localparam int SL = plvl_pkg::SNAPSHOT_LEVELS;
	localparam int PW = plvl_pkg::PW;

	plvl_pkg::state_t state_q, state_d;
	plvl_pkg::in_item_t item_q;
	plvl_pkg::out_item_t out_q;
	logic out_valid_q;
	logic [6:0] md_q;
	logic [1:0] pol_q;
	logic [2:0] status_q, status_d;
	logic [2:0] err_q, err_d;
	logic [31:0] snap_q, snap_d;
	logic commit_q, commit_d;
	logic [plvl_pkg::BK_CW-1:0] bk_cnt_q [2];
	logic [plvl_pkg::BK_CW-1:0] bk_cnt_d [2];
	logic [plvl_pkg::ST_CW-1:0] st_cnt_q [2];
	logic [plvl_pkg::ST_CW-1:0] st_cnt_d [2];
	logic out_load;

	plvl_pkg::cell_ctl_t bk_ctl [2];
	plvl_pkg::cell_ctl_t st_ctl [2];

	wire [PW-1:0] bk_p [2][BL];
	wire [PW-1:0] bk_q [2][BL];
	wire [BL-1:0] bk_bet [2];
	wire [BL-1:0] bk_mat [2];
	wire [PW-1:0] bk_qp [2][BL];
	wire [PW-1:0] bk_qq [2][BL];
	wire [PW-1:0] st_p [2][SL];
	wire [PW-1:0] st_q [2][SL];
	wire [SL-1:0] st_bet [2];
	wire [SL-1:0] st_mat [2];

	logic [PW-1:0] key_p;
	logic [PW-1:0] key_q;

	assign key_p = item_q.price[PW-1:0];
	assign key_q = item_q.quantity[PW-1:0];

	for (genvar s = 0; s < 2; s++) begin : g_bk
		for (genvar j = 0; j < BL; j++) begin : g_c
			logic [PW-1:0] lp, lq, rp, rq, xp, xq;
			logic pb;
			if (j == 0) begin : g_first
				assign lp = key_p;
				assign lq = key_q;
				assign pb = 1'b1;
			end else begin : g_mid
				assign lp = bk_p[s][j-1];
				assign lq = bk_q[s][j-1];
				assign pb = bk_bet[s][j-1];
			end
			if (j == BL - 1) begin : g_end
				assign rp = '0;
				assign rq = '0;
			end else begin : g_nxt
				assign rp = bk_p[s][j+1];
				assign rq = bk_q[s][j+1];
			end
			if (j < SL) begin : g_ext
				assign xp = st_p[s][j];
				assign xq = st_q[s][j];
			end else begin : g_noext
				assign xp = '0;
				assign xq = '0;
			end
			plvl_cell u_cell (
				.clk(clk),
				.ctl(bk_ctl[s]),
				.valid(j < int'(bk_cnt_q[s])),
				.key_p(key_p),
				.key_q(key_q),
				.prev_better(pb),
				.left_p(lp),
				.left_q(lq),
				.right_p(rp),
				.right_q(rq),
				.ext_p(xp),
				.ext_q(xq),
				.lvl_p(bk_p[s][j]),
				.lvl_q(bk_q[s][j]),
				.better(bk_bet[s][j]),
				.match(bk_mat[s][j])
			);
			assign bk_qp[s][j] = (j == int'(item_q.query_index)) ? bk_p[s][j] : '0;
			assign bk_qq[s][j] = (j == int'(item_q.query_index)) ? bk_q[s][j] : '0;
		end
	end

	for (genvar s = 0; s < 2; s++) begin : g_st
		for (genvar j = 0; j < SL; j++) begin : g_c
			logic [PW-1:0] lp, lq, rp, rq;
			logic pb;
			if (j == 0) begin : g_first
				assign lp = key_p;
				assign lq = key_q;
				assign pb = 1'b1;
			end else begin : g_mid
				assign lp = st_p[s][j-1];
				assign lq = st_q[s][j-1];
				assign pb = st_bet[s][j-1];
			end
			if (j == SL - 1) begin : g_end
				assign rp = '0;
				assign rq = '0;
			end else begin : g_nxt
				assign rp = st_p[s][j+1];
				assign rq = st_q[s][j+1];
			end
			plvl_cell u_cell (
				.clk(clk),
				.ctl(st_ctl[s]),
				.valid(j < int'(st_cnt_q[s])),
				.key_p(key_p),
				.key_q(key_q),
				.prev_better(pb),
				.left_p(lp),
				.left_q(lq),
				.right_p(rp),
				.right_q(rq),
				.ext_p('0),
				.ext_q('0),
				.lvl_p(st_p[s][j]),
				.lvl_q(st_q[s][j]),
				.better(st_bet[s][j]),
				.match(st_mat[s][j])
			);
		end
	end

	logic bk_crossed, st_crossed;
	logic bad_price, neg_qty, qty_zero;

	always_comb begin
		bk_crossed = (bk_cnt_q[0] != '0) && (bk_cnt_q[1] != '0) && (bk_p[0][0] >= bk_p[1][0]);
		st_crossed = (st_cnt_q[0] != '0) && (st_cnt_q[1] != '0) && (st_p[0][0] >= st_p[1][0]);
		bad_price = (item_q.price == '0) || item_q.price[31];
		neg_qty = item_q.quantity[31];
		qty_zero = (item_q.quantity == '0);
	end

	// query read: one-hot select of the addressed cell on the item's side
	logic [PW-1:0] qry_p, qry_q;
	logic qry_found;

	always_comb begin
		qry_p = '0;
		qry_q = '0;
		for (int j = 0; j < BL; j++) begin
			qry_p = qry_p | bk_qp[item_q.side][j];
			qry_q = qry_q | bk_qq[item_q.side][j];
		end
		qry_found = (item_q.action == plvl_pkg::ACT_QUERY)
			&& (32'(item_q.query_index) < 32'(bk_cnt_q[item_q.side]));
	end

	always_comb begin
		logic sd, os;
		logic any_hit, ins0, rem0, nb_ok, oth_ok, would_cross;
		logic [PW-1:0] nb_p, oth_p;
		logic [2:0] sts;
		state_d = state_q;
		status_d = status_q;
		err_d = err_q;
		snap_d = snap_q;
		commit_d = commit_q;
		bk_cnt_d = bk_cnt_q;
		st_cnt_d = st_cnt_q;
		out_load = 1'b0;
		sd = item_q.side;
		os = ~item_q.side;
		for (int s = 0; s < 2; s++) begin
			bk_ctl[s].cmd = plvl_pkg::CMD_HOLD;
			bk_ctl[s].side = s[0];
			st_ctl[s].cmd = plvl_pkg::CMD_HOLD;
			st_ctl[s].side = s[0];
		end
		any_hit = |bk_mat[sd];
		ins0 = !any_hit && !qty_zero && !bk_bet[sd][0];
		rem0 = any_hit && qty_zero && bk_mat[sd][0];
		if (ins0) begin
			nb_ok = 1'b1;
			nb_p = key_p;
		end else if (rem0) begin
			nb_ok = 32'(bk_cnt_q[sd]) > 32'd1;
			nb_p = bk_p[sd][1];
		end else begin
			nb_ok = bk_cnt_q[sd] != '0;
			nb_p = bk_p[sd][0];
		end
		oth_ok = bk_cnt_q[os] != '0;
		oth_p = bk_p[os][0];
		would_cross = nb_ok && oth_ok
			&& ((sd == plvl_pkg::SIDE_BID) ? (nb_p >= oth_p) : (oth_p >= nb_p));
		sts = plvl_pkg::STS_OK;

		unique case (state_q)
			plvl_pkg::S_IDLE: begin
				if (in_valid) begin
					state_d = plvl_pkg::S_EXEC;
				end
			end
			plvl_pkg::S_EXEC: begin
				commit_d = 1'b0;
				unique case (item_q.action)
					plvl_pkg::ACT_UPDATE: begin
						state_d = plvl_pkg::S_DONE;
						if (bad_price) begin
							status_d = plvl_pkg::STS_BAD_PRICE;
						end else if (neg_qty) begin
							status_d = plvl_pkg::STS_NEG_QTY;
						end else if (would_cross && pol_q == plvl_pkg::POL_REJECT) begin
							status_d = plvl_pkg::STS_CROSSED;
						end else begin
							status_d = plvl_pkg::STS_OK;
							state_d = (pol_q == plvl_pkg::POL_DROP)
								? plvl_pkg::S_DROP : plvl_pkg::S_TRIM;
							if (any_hit && qty_zero) begin
								bk_ctl[sd].cmd = plvl_pkg::CMD_REMOVE;
								bk_cnt_d[sd] = bk_cnt_q[sd] - 1'b1;
							end else if (any_hit) begin
								bk_ctl[sd].cmd = plvl_pkg::CMD_QTY;
							end else if (!qty_zero) begin
								bk_ctl[sd].cmd = plvl_pkg::CMD_INSERT;
								if (!bk_bet[sd][BL-1]
										&& bk_cnt_q[sd] != plvl_pkg::BK_CW'(BL)) begin
									bk_cnt_d[sd] = bk_cnt_q[sd] + 1'b1;
								end
							end
						end
					end
					plvl_pkg::ACT_SNAPSHOT: begin
						if (neg_qty) begin
							sts = plvl_pkg::STS_NEG_QTY;
						end else if (!qty_zero && bad_price) begin
							sts = plvl_pkg::STS_BAD_PRICE;
						end
						status_d = sts;
						if (err_q == plvl_pkg::STS_OK) begin
							err_d = sts;
						end
						if (err_d == plvl_pkg::STS_OK && !qty_zero) begin
							if (|st_mat[sd]) begin
								st_ctl[sd].cmd = plvl_pkg::CMD_QTY;
							end else begin
								st_ctl[sd].cmd = plvl_pkg::CMD_INSERT;
								if (!st_bet[sd][SL-1]
										&& st_cnt_q[sd] != plvl_pkg::ST_CW'(SL)) begin
									st_cnt_d[sd] = st_cnt_q[sd] + 1'b1;
								end
							end
						end
						state_d = item_q.last ? plvl_pkg::S_COMMIT : plvl_pkg::S_DONE;
					end
					plvl_pkg::ACT_TRADE: begin
						status_d = plvl_pkg::STS_IGNORED;
						state_d = plvl_pkg::S_DONE;
					end
					plvl_pkg::ACT_QUERY: begin
						status_d = plvl_pkg::STS_OK;
						state_d = plvl_pkg::S_DONE;
					end
				endcase
			end
			plvl_pkg::S_COMMIT: begin
				state_d = plvl_pkg::S_DONE;
				if (err_q != plvl_pkg::STS_OK) begin
					status_d = err_q;
				end else if (pol_q == plvl_pkg::POL_REJECT && st_crossed) begin
					status_d = plvl_pkg::STS_CROSSED;
				end else begin
					status_d = plvl_pkg::STS_OK;
					commit_d = 1'b1;
					snap_d = snap_q + 32'd1;
					for (int s = 0; s < 2; s++) begin
						bk_ctl[s].cmd = plvl_pkg::CMD_LOAD;
						bk_cnt_d[s] = (32'(st_cnt_q[s]) > BL)
							? plvl_pkg::BK_CW'(BL) : plvl_pkg::BK_CW'(st_cnt_q[s]);
					end
					state_d = (pol_q == plvl_pkg::POL_DROP) ? plvl_pkg::S_DROP : plvl_pkg::S_TRIM;
				end
				st_cnt_d[0] = '0;
				st_cnt_d[1] = '0;
				err_d = plvl_pkg::STS_OK;
			end
			plvl_pkg::S_DROP: begin
				// pop one best level per cycle until the book is no longer crossed
				if (bk_crossed) begin
					if (commit_q) begin
						if (bk_q[0][0] <= bk_q[1][0]) begin
							bk_ctl[0].cmd = plvl_pkg::CMD_POP;
							bk_cnt_d[0] = bk_cnt_q[0] - 1'b1;
						end else begin
							bk_ctl[1].cmd = plvl_pkg::CMD_POP;
							bk_cnt_d[1] = bk_cnt_q[1] - 1'b1;
						end
					end else begin
						bk_ctl[sd].cmd = plvl_pkg::CMD_POP;
						bk_cnt_d[sd] = bk_cnt_q[sd] - 1'b1;
					end
				end else begin
					state_d = plvl_pkg::S_TRIM;
				end
			end
			plvl_pkg::S_TRIM: begin
				for (int s = 0; s < 2; s++) begin
					if (md_q != '0 && 32'(bk_cnt_q[s]) > 32'(md_q)) begin
						bk_cnt_d[s] = plvl_pkg::BK_CW'(md_q);
					end
				end
				state_d = plvl_pkg::S_DONE;
			end
			plvl_pkg::S_DONE: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d = plvl_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = plvl_pkg::S_IDLE;
			end
		endcase
	end

	assign in_ready = (state_q == plvl_pkg::S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= plvl_pkg::S_IDLE;
			out_valid_q <= 1'b0;
			md_q <= '0;
			pol_q <= '0;
			err_q <= '0;
			snap_q <= '0;
			commit_q <= 1'b0;
			bk_cnt_q[0] <= '0;
			bk_cnt_q[1] <= '0;
			st_cnt_q[0] <= '0;
			st_cnt_q[1] <= '0;
		end else begin
			state_q <= state_d;
			err_q <= err_d;
			snap_q <= snap_d;
			commit_q <= commit_d;
			bk_cnt_q <= bk_cnt_d;
			st_cnt_q <= st_cnt_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					plvl_pkg::CFG_MAX_DEPTH: md_q <= cfg_data;
					plvl_pkg::CFG_POLICY: pol_q <= cfg_data[1:0];
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		status_q <= status_d;
		if (in_valid && in_ready) begin
			item_q <= in_data;
		end
		if (out_load) begin
			out_q.status <= status_q;
			out_q.best_bid_price <= (bk_cnt_q[0] != '0) ? bk_p[0][0] : '0;
			out_q.best_bid_qty <= (bk_cnt_q[0] != '0) ? bk_q[0][0] : '0;
			out_q.best_ask_price <= (bk_cnt_q[1] != '0) ? bk_p[1][0] : '0;
			out_q.best_ask_qty <= (bk_cnt_q[1] != '0) ? bk_q[1][0] : '0;
			out_q.bid_count <= 7'(bk_cnt_q[0]);
			out_q.ask_count <= 7'(bk_cnt_q[1]);
			out_q.crossed <= bk_crossed;
			out_q.snapshot_count <= snap_q;
			out_q.level_found <= qry_found;
			out_q.level_price <= qry_found ? qry_p : '0;
			out_q.level_qty <= qry_found ? qry_q : '0;
		end
	end

endmodule

### design/plvl_check.sv
module plvl_check (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input plvl_pkg::out_item_t out_data
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result item changed while stalled");

	a_crossed_sides: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.crossed |-> out_data.bid_count != 7'd0
			&& out_data.ask_count != 7'd0
			&& out_data.best_bid_price >= out_data.best_ask_price)
		else $error("crossed flag without a crossed book");

	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.level_found |-> out_data.status == plvl_pkg::STS_OK
			&& (out_data.bid_count != 7'd0 || out_data.ask_count != 7'd0))
		else $error("query hit on a bad status or empty book");

	a_empty_bid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.bid_count == 7'd0 |-> out_data.best_bid_price == '0
			&& out_data.best_bid_qty == '0)
		else $error("empty bid side shows a best level");

endmodule

bind price_level_order_book_top plvl_check u_plvl_check (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_data(out_data)
);

### verif/price_level_order_book_checker.sv
module price_level_order_book_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input plvl_pkg::in_item_t in_data,
	input logic out_valid,
	input logic out_ready,
	input plvl_pkg::out_item_t out_data,
	input logic cfg_we,
	input logic cfg_index,
	input logic [6:0] cfg_data,
	output int fail_count,
	output int pending_count
);

	typedef struct {
		logic [31:0] p[$];
		logic [31:0] q[$];
	} level_tab_t;

	level_tab_t bids, asks, st_bids, st_asks;
	logic [1:0] stage_err;
	logic [31:0] snap_ctr;
	logic [6:0] depth_lim;
	logic [1:0] policy;
	plvl_pkg::out_item_t book_results[$];

	function automatic bit ahead(logic sd, logic [31:0] a, logic [31:0] b);
		return sd ? (a < b) : (a > b);
	endfunction

	function automatic void put_level(ref level_tab_t t, input int cap, input logic sd,
			input logic [31:0] pr, input logic [31:0] qt);
		int i;
		i = 0;
		while (i < t.p.size() && ahead(sd, t.p[i], pr))
			i++;
		if (i < t.p.size() && t.p[i] == pr) begin
			if (qt == 0) begin
				t.p.delete(i);
				t.q.delete(i);
			end else
				t.q[i] = qt;
			return;
		end
		if (qt == 0 || i >= cap)
			return;
		if (t.p.size() >= cap) begin
			void'(t.p.pop_back());
			void'(t.q.pop_back());
		end
		t.p.insert(i, pr);
		t.q.insert(i, qt);
	endfunction

	function automatic bit is_x_book(level_tab_t b, level_tab_t a);
		return b.p.size() != 0 && a.p.size() != 0 && b.p[0] >= a.p[0];
	endfunction

	function automatic void trim_side(ref level_tab_t t);
		while (depth_lim != 0 && t.p.size() > depth_lim) begin
			void'(t.p.pop_back());
			void'(t.q.pop_back());
		end
	endfunction

	// chg: 0 bid updated, 1 ask updated, 2 commit (smaller qty goes, bid on tie)
	function automatic void uncross(int chg);
		while (is_x_book(bids, asks)) begin
			if (chg == 0 || (chg == 2 && bids.q[0] <= asks.q[0])) begin
				void'(bids.p.pop_front());
				void'(bids.q.pop_front());
			end else begin
				void'(asks.p.pop_front());
				void'(asks.q.pop_front());
			end
		end
	endfunction

	function automatic plvl_pkg::out_item_t apply_item(plvl_pkg::in_item_t it);
		plvl_pkg::out_item_t r;
		logic [31:0] pr, qt;
		bit bad_pr, neg;
		level_tab_t sb, sa;
		logic [2:0] st;
		r = '0;
		pr = it.price;
		qt = it.quantity;
		bad_pr = (pr == 0) || pr[31];
		neg = qt[31];
		st = plvl_pkg::STS_OK;
		case (it.action)
			plvl_pkg::ACT_UPDATE: begin
				if (bad_pr)
					st = plvl_pkg::STS_BAD_PRICE;
				else if (neg)
					st = plvl_pkg::STS_NEG_QTY;
				else begin
					sb = bids;
					sa = asks;
					if (it.side) put_level(asks, plvl_pkg::BOOK_LEVELS, 1, pr, qt);
					else put_level(bids, plvl_pkg::BOOK_LEVELS, 0, pr, qt);
					if (is_x_book(bids, asks)) begin
						if (policy == plvl_pkg::POL_REJECT) begin
							bids = sb;
							asks = sa;
							st = plvl_pkg::STS_CROSSED;
						end else if (policy == plvl_pkg::POL_DROP)
							uncross(int'(it.side));
					end
					if (st == plvl_pkg::STS_OK) begin
						trim_side(bids);
						trim_side(asks);
					end
				end
			end
			plvl_pkg::ACT_SNAPSHOT: begin
				if (neg)
					st = plvl_pkg::STS_NEG_QTY;
				else if (qt != 0 && bad_pr)
					st = plvl_pkg::STS_BAD_PRICE;
				if (st != plvl_pkg::STS_OK && stage_err == 0)
					stage_err = st[1:0];
				if (stage_err == 0 && qt != 0) begin
					if (it.side) put_level(st_asks, plvl_pkg::SNAPSHOT_LEVELS, 1, pr, qt);
					else put_level(st_bids, plvl_pkg::SNAPSHOT_LEVELS, 0, pr, qt);
				end
				if (it.last) begin
					if (stage_err != 0)
						st = {1'b0, stage_err};
					else if (policy == plvl_pkg::POL_REJECT && is_x_book(st_bids, st_asks))
						st = plvl_pkg::STS_CROSSED;
					else begin
						bids = st_bids;
						asks = st_asks;
						while (bids.p.size() > plvl_pkg::BOOK_LEVELS) begin
							void'(bids.p.pop_back());
							void'(bids.q.pop_back());
						end
						while (asks.p.size() > plvl_pkg::BOOK_LEVELS) begin
							void'(asks.p.pop_back());
							void'(asks.q.pop_back());
						end
						if (policy == plvl_pkg::POL_DROP)
							uncross(2);
						trim_side(bids);
						trim_side(asks);
						snap_ctr++;
						st = plvl_pkg::STS_OK;
					end
					st_bids.p.delete();
					st_bids.q.delete();
					st_asks.p.delete();
					st_asks.q.delete();
					stage_err = 0;
				end
			end
			plvl_pkg::ACT_TRADE: st = plvl_pkg::STS_IGNORED;
			default: begin
				if (it.side) begin
					if (it.query_index < asks.p.size()) begin
						r.level_found = 1;
						r.level_price = asks.p[it.query_index][30:0];
						r.level_qty = asks.q[it.query_index][30:0];
					end
				end else if (it.query_index < bids.p.size()) begin
					r.level_found = 1;
					r.level_price = bids.p[it.query_index][30:0];
					r.level_qty = bids.q[it.query_index][30:0];
				end
			end
		endcase
		r.status = st;
		if (bids.p.size() != 0) begin
			r.best_bid_price = bids.p[0][30:0];
			r.best_bid_qty = bids.q[0][30:0];
		end
		if (asks.p.size() != 0) begin
			r.best_ask_price = asks.p[0][30:0];
			r.best_ask_qty = asks.q[0][30:0];
		end
		r.bid_count = 7'(bids.p.size());
		r.ask_count = 7'(asks.p.size());
		r.crossed = is_x_book(bids, asks);
		r.snapshot_count = snap_ctr;
		return r;
	endfunction

	assign pending_count = book_results.size();

	initial begin
		fail_count = 0;
		stage_err = 0;
		snap_ctr = 0;
		depth_lim = 0;
		policy = 0;
	end

	always @(posedge clk) begin
		plvl_pkg::out_item_t want;
		if (arst_n) begin
			if (cfg_we) begin
				if (cfg_index == plvl_pkg::CFG_MAX_DEPTH) depth_lim = cfg_data;
				else policy = cfg_data[1:0];
			end
			if (in_valid && in_ready)
				book_results.push_back(apply_item(in_data));
			if (out_valid && out_ready) begin
				if (book_results.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected result, expected none, got %p", $time, out_data);
				end else begin
					want = book_results.pop_front();
					if (out_data !== want) begin
						fail_count++;
						$display("%0t: mismatch expected %p", $time, want);
						$display("%0t:          actual   %p", $time, out_data);
					end
				end
			end
		end
	end
endmodule

### verif/price_level_order_book_top_tb.sv
module price_level_order_book_top_tb;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	plvl_pkg::in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 0;
	plvl_pkg::out_item_t out_data;
	logic cfg_we = 0;
	logic cfg_index = 0;
	logic [6:0] cfg_data = 0;
	int fail_count, pending_count;
	int cycle_ctr = 0;
	bit calm = 0;
	int in_gap = 0;
	logic [31:0] price_base = 1000;

	price_level_order_book_top uut (.*);
	price_level_order_book_checker chk (.*);

	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	always @(posedge clk) begin
		cycle_ctr <= cycle_ctr + 1;
		if (cycle_ctr > 400000) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// receiver stalls in bursts
	initial begin
		int n;
		forever begin
			@(posedge clk);
			if (!calm && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 14);
				out_ready <= 0;
				repeat (n) @(posedge clk);
			end
			out_ready <= 1;
		end
	end

	task automatic send(logic [1:0] act, logic sd, logic [31:0] pr, logic [31:0] qt,
			logic [5:0] qi, logic lst);
		plvl_pkg::in_item_t it;
		it.action = act;
		it.side = sd;
		it.price = pr;
		it.quantity = qt;
		it.query_index = qi;
		it.last = lst;
		if (!calm && $urandom_range(0, 6) == 0)
			repeat ($urandom_range(1, 14)) @(posedge clk);
		in_valid <= 1;
		in_data <= it;
		do @(posedge clk); while (!in_ready);
		in_valid <= 0;
		// block is busy after an accept; step past this edge
		@(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [6:0] v);
		int guard;
		guard = 0;
		while (pending_count != 0 && guard < 100000) begin
			@(posedge clk);
			guard++;
		end
		repeat (12) @(posedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 0;
	endtask

	// prices near a moving base so levels collide and cross
	function automatic logic [31:0] near_price(logic sd);
		return sd ? price_base + $urandom_range(0, 40) - 5 : price_base - $urandom_range(0, 40) + 5;
	endfunction

	task automatic random_item();
		int k;
		logic sd;
		logic [31:0] pr, qt;
		k = $urandom_range(0, 99);
		sd = 1'($urandom_range(0, 1));
		pr = near_price(sd);
		qt = $urandom_range(0, 6) == 0 ? 0 : $urandom_range(1, 500);
		if (k < 3) pr = $urandom;
		if (k >= 3 && k < 6) qt = $urandom;
		if (k < 50)
			send(plvl_pkg::ACT_UPDATE, sd, pr, qt, 6'($urandom), 1'($urandom));
		else if (k < 72) begin
			// well-formed snapshot, occasionally broken
			int n;
			n = $urandom_range(1, 12);
			for (int j = 0; j < n; j++) begin
				sd = 1'($urandom_range(0, 1));
				pr = near_price(sd);
				qt = $urandom_range(1, 500);
				if ($urandom_range(0, 30) == 0) qt = $urandom;
				if ($urandom_range(0, 30) == 0) pr = -$urandom_range(0, 3);
				send(plvl_pkg::ACT_SNAPSHOT, sd, pr, qt, 6'($urandom), j == n - 1);
			end
			price_base = price_base + $urandom_range(0, 20) - 10;
		end else if (k < 77)
			send(plvl_pkg::ACT_TRADE, 1'($urandom), $urandom, $urandom, 6'($urandom),
				1'($urandom));
		else
			send(plvl_pkg::ACT_QUERY, sd, $urandom, $urandom, 6'($urandom_range(0, 70)),
				1'($urandom));
	endtask

	initial begin
		int guard;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// field extremes and special cases
		send(plvl_pkg::ACT_UPDATE, plvl_pkg::SIDE_BID, 32'h8000_0000, 5, 0, 0);
		send(plvl_pkg::ACT_UPDATE, plvl_pkg::SIDE_BID, 0, 5, 0, 0);
		send(plvl_pkg::ACT_UPDATE, 1, 100, 32'h8000_0000, 0, 0);
		send(plvl_pkg::ACT_UPDATE, plvl_pkg::SIDE_BID, 32'h7fff_ffff, 32'h7fff_ffff, 6'h3f, 1);
		send(plvl_pkg::ACT_UPDATE, plvl_pkg::SIDE_BID, 500, 0, 0, 0);
		send(plvl_pkg::ACT_UPDATE, plvl_pkg::SIDE_BID, 32'h7fff_ffff, 0, 0, 0);
		send(plvl_pkg::ACT_UPDATE, plvl_pkg::SIDE_BID, 99, 10, 0, 0);
		send(plvl_pkg::ACT_UPDATE, 1, 100, 20, 0, 0);
		send(plvl_pkg::ACT_UPDATE, 1, 90, 20, 0, 0);
		send(plvl_pkg::ACT_QUERY, 1, 0, 0, 0, 0);
		send(plvl_pkg::ACT_QUERY, 1, 0, 0, 6'h3f, 0);
		send(plvl_pkg::ACT_TRADE, 1, 32'hffff_ffff, 32'hffff_ffff, 6'h3f, 1);
		send(plvl_pkg::ACT_SNAPSHOT, plvl_pkg::SIDE_BID, 0, 0, 0, 0);
		send(plvl_pkg::ACT_SNAPSHOT, plvl_pkg::SIDE_BID, 98, 7, 0, 0);
		send(plvl_pkg::ACT_SNAPSHOT, plvl_pkg::SIDE_BID, 98, 9, 0, 0);
		send(plvl_pkg::ACT_SNAPSHOT, 1, 101, 3, 0, 1);
		send(plvl_pkg::ACT_SNAPSHOT, 1, -5, 3, 0, 0);
		send(plvl_pkg::ACT_SNAPSHOT, 1, 105, 3, 0, 1);
		send(plvl_pkg::ACT_SNAPSHOT, 1, 105, -3, 0, 1);
		// send 70 bid updates, more than the 64-level capacity of the bid side
		for (int i = 0; i < 70; i++)
			send(plvl_pkg::ACT_UPDATE, plvl_pkg::SIDE_BID, 10 + $urandom_range(0, 80), 1 + i,
				0, 0);
		send(plvl_pkg::ACT_QUERY, plvl_pkg::SIDE_BID, 0, 0, 63, 0);
		// random phases through the register settings
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: write_reg(plvl_pkg::CFG_POLICY, 1);
				1: write_reg(plvl_pkg::CFG_MAX_DEPTH, 1);
				2: write_reg(plvl_pkg::CFG_POLICY, 2);
				3: write_reg(plvl_pkg::CFG_MAX_DEPTH, 64);
				4: write_reg(plvl_pkg::CFG_POLICY, 3);
				5: write_reg(plvl_pkg::CFG_MAX_DEPTH, 7'h7f);
				6: write_reg(plvl_pkg::CFG_POLICY, 0);
				default: begin
					write_reg(plvl_pkg::CFG_MAX_DEPTH, 5);
					calm = 1;
				end
			endcase
			for (int i = 0; i < 38; i++)
				random_item();
		end
		guard = 0;
		while (pending_count != 0 && guard < 100000) begin
			@(posedge clk);
			guard++;
		end
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
